>>> design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared widths, constants and controller/datapath bundles for the
// trial-division prime tester
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // candidate width
  localparam int NUM_W  = 31;
  // trial divisor width, enough for sqrt(2^NUM_W) plus one odd step
  localparam int DIV_W  = NUM_W / 2 + 2;
  // width of the running divisor square
  localparam int SQ_W   = 2 * DIV_W;
  // bit index into the candidate
  localparam int BIT_W  = $clog2(NUM_W);
  // prime counter
  localparam int CNT_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [NUM_W-1:0] SMALLEST_PRIME = NUM_W'(2);
  localparam logic [DIV_W-1:0] FIRST_DIV      = DIV_W'(3);
  localparam logic [SQ_W-1:0]  FIRST_SQ       = SQ_W'(9);
  localparam logic [BIT_W-1:0] TOP_BIT        = BIT_W'(NUM_W - 1);

  // controller to datapath
  typedef struct packed {
    logic load;       // latch candidate, reset divisor to three
    logic start_div;  // clear remainder, point at top candidate bit
    logic div_step;   // one restoring remainder step
    logic next_div;   // advance to next odd divisor
    logic finish;     // load output register and count
    logic verdict;    // prime verdict carried with finish
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trivial_np; // below two or even and not two
    logic sq_gt;      // divisor squared exceeds candidate
    logic div_last;   // remainder step on bit zero
    logic rem_zero;   // remainder is zero
    logic out_free;   // output register can take a result
  } status_t;

endpackage

>>> design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test by trial division with a saturating count of primes seen
// ----------------------------------------------------------------------------
//
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_ready_o, candidate_i       | to block
// out      | out_valid_o, out_ready_i, is_prime_flag_o, | from block
//          | prime_total_o                             |
//
// flow: values below two and even values go from the check straight to the
// finish step; an odd prime tries every odd divisor from three up to the
// square root, and an odd composite stops at its smallest odd factor. each
// divisor takes a full pass of the single restoring remainder unit, which
// consumes one candidate bit a cycle.
// reset clears the sequencer, the output valid and the prime count.
// a new candidate transfer is taken whenever the sequencer is idle, even while
// a result still waits in the output register; a stalled output holds the
// finished verdict back until the register frees up.
//
module trial_division_prime_test (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tdpt_pkg::NUM_W-1:0]  candidate_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_prime_flag_o,
  output logic [tdpt_pkg::CNT_W-1:0]  prime_total_o
);

  // command and status bundles between sequencer and datapath
  tdpt_pkg::cmd_t    cmd;
  tdpt_pkg::status_t status;

  // sequencer: small/even screen, square-root bound, divide, remainder test
  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: divisor and its square kept incrementally, bit-serial remainder,
  // counter and output register
  tdpt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .candidate_i     (candidate_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_prime_flag_o (is_prime_flag_o),
    .prime_total_o   (prime_total_o)
  );

endmodule

>>> design/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// sequencer for the trial-division loop
// ----------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tdpt_pkg::status_t status_i,
  output tdpt_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_REMAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   verdict_q, verdict_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    verdict_d = verdict_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.trivial_np) begin
          verdict_d = 1'b0;
          state_d   = ST_FINISH;
        end else if (status_i.sq_gt) begin
          verdict_d = 1'b1;
          state_d   = ST_FINISH;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_REMAIN;
        end
      end
      ST_REMAIN: begin
        if (status_i.rem_zero) begin
          verdict_d = 1'b0;
          state_d   = ST_FINISH;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.verdict = verdict_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      verdict_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> design/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp
// candidate, divisor and square registers, bit-serial remainder unit,
// prime counter and output register
// ----------------------------------------------------------------------------
module tdpt_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tdpt_pkg::NUM_W-1:0]  candidate_i,
  input  tdpt_pkg::cmd_t              cmd_i,
  output tdpt_pkg::status_t           status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_prime_flag_o,
  output logic [tdpt_pkg::CNT_W-1:0]  prime_total_o
);

  logic [tdpt_pkg::NUM_W-1:0] cand_q;
  logic [tdpt_pkg::DIV_W-1:0] div_q;
  logic [tdpt_pkg::SQ_W-1:0]  sq_q;
  logic [tdpt_pkg::DIV_W-1:0] rem_q;
  logic [tdpt_pkg::BIT_W-1:0] bit_q;
  logic                       out_valid_q;
  logic                       flag_q;
  logic [tdpt_pkg::CNT_W-1:0] count_q, count_d;

  logic [tdpt_pkg::DIV_W:0]   r_shift;
  logic [tdpt_pkg::DIV_W-1:0] r_sub;
  logic                       r_ge;
  logic [tdpt_pkg::DIV_W-1:0] rem_next;

  // restoring remainder, one candidate bit per cycle while div_step is asserted
  assign r_shift  = {rem_q, cand_q[bit_q]};
  assign r_ge     = (r_shift >= {1'b0, div_q});
  // difference is below the divisor whenever it is taken
  assign r_sub    = r_shift[tdpt_pkg::DIV_W-1:0] - div_q;
  assign rem_next = r_ge ? r_sub : r_shift[tdpt_pkg::DIV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cand_q <= candidate_i;
      div_q  <= tdpt_pkg::FIRST_DIV;
      sq_q   <= tdpt_pkg::FIRST_SQ;
    end else if (cmd_i.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div_q <= div_q + tdpt_pkg::DIV_W'(2);
      sq_q  <= sq_q + tdpt_pkg::SQ_W'({div_q, 2'b00}) + tdpt_pkg::SQ_W'(4);
    end
    if (cmd_i.start_div) begin
      rem_q <= '0;
      bit_q <= tdpt_pkg::TOP_BIT;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      bit_q <= bit_q - tdpt_pkg::BIT_W'(1);
    end
    if (cmd_i.finish) begin
      flag_q <= cmd_i.verdict;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish && cmd_i.verdict && (count_q != tdpt_pkg::CNT_MAX)) begin
      count_d = count_q + tdpt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.trivial_np = (cand_q[tdpt_pkg::NUM_W-1:1] == '0)
                            || (!cand_q[0] && (cand_q != tdpt_pkg::SMALLEST_PRIME));
  assign status_o.sq_gt      = (sq_q > tdpt_pkg::SQ_W'(cand_q));
  assign status_o.div_last   = (bit_q == '0);
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign is_prime_flag_o = flag_q;
  assign prime_total_o   = count_q;

endmodule

>>> design/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker
// port-level checks for the trial-division prime tester
// ----------------------------------------------------------------------------
module tdpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [tdpt_pkg::NUM_W-1:0]  candidate_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        is_prime_flag_o,
  input logic [tdpt_pkg::CNT_W-1:0]  prime_total_o
);

  logic                       in_xfer, out_xfer;
  logic [1:0]                 pend_q;
  logic [tdpt_pkg::CNT_W-1:0] last_total_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items taken but not yet delivered, and last delivered count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_total_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer) begin
        last_total_q <= prime_total_o;
      end
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(candidate_i))
    else $error("input transfer dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(is_prime_flag_o) && $stable(prime_total_o))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> pend_q != 2'd0) && (pend_q != 2'd3))
    else $error("result without a pending item or too many items pending");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (!is_prime_flag_o && prime_total_o == last_total_q)
      || (is_prime_flag_o && prime_total_o == last_total_q + tdpt_pkg::CNT_W'(1))
      || (is_prime_flag_o && last_total_q == tdpt_pkg::CNT_MAX
          && prime_total_o == tdpt_pkg::CNT_MAX))
    else $error("prime total does not follow verdict");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);
